FILE: rtl/rpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared widths, step counts and register indexes for the RMS and peak meter.
// ----------------------------------------------------------------------------
package rpm_pkg;

   // Default values for the top-level parameters.
   localparam int MAX_CHANNELS_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 24;

   // Fixed field widths.
   localparam int FRAME_W  = 40;
   localparam int SUM_W    = 64;
   localparam int LEN_W    = 24;
   localparam int CHCNT_W  = 5;
   localparam int FLOOR_W  = 23;
   localparam int CH_OUT_W = 4;
   localparam int ROOT_W   = SUM_W / 2;

   // Shared compare and subtract unit: wide enough for the root remainder.
   localparam int ALU_W = ROOT_W + 4;

   // Iteration counts of the shared unit.
   localparam int MOD_STEPS  = FRAME_W;
   localparam int DIV_STEPS  = SUM_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int STEP_W     = 7;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_POINT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_LEVEL       = 2'd2;

endpackage

FILE: rtl/rpm_cmpsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_cmpsub
// Shared compare and subtract unit used by the modulo, divide and root steps.
// ----------------------------------------------------------------------------
module rpm_cmpsub (
   input  logic [rpm_pkg::ALU_W-1:0] a,
   input  logic [rpm_pkg::ALU_W-1:0] b,
   output logic                      ge,
   output logic [rpm_pkg::ALU_W-1:0] diff
);

   logic [rpm_pkg::ALU_W:0] wide;

   // A borrow out of the top bit means a is below b.
   assign wide = {1'b0, a} - {1'b0, b};
   assign ge   = ~wide[rpm_pkg::ALU_W];
   assign diff = wide[rpm_pkg::ALU_W-1:0];

endmodule

FILE: rtl/rpm_chan_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_chan_store
// Per-channel sum of squares and peak memory, with valid bits so that every
// entry reads as zero after reset.
// ----------------------------------------------------------------------------
module rpm_chan_store #(
   parameter int DEPTH  = rpm_pkg::MAX_CHANNELS_DEF,
   parameter int ADDR_W = 4,
   parameter int PEAK_W = rpm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [rpm_pkg::SUM_W-1:0] wr_sum,
   input  logic [PEAK_W-1:0]         wr_peak,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [rpm_pkg::SUM_W-1:0] rd_sum,
   output logic [PEAK_W-1:0]         rd_peak
);

   logic [rpm_pkg::SUM_W-1:0] sum_mem [DEPTH];
   logic [PEAK_W-1:0]         peak_mem [DEPTH];
   logic [DEPTH-1:0]          valid_ff;
   logic [DEPTH-1:0]          valid_in;
   logic                      rd_valid_ff;
   logic [rpm_pkg::SUM_W-1:0] rd_sum_ff;
   logic [PEAK_W-1:0]         rd_peak_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_mem[wr_addr]  <= wr_sum;
         peak_mem[wr_addr] <= wr_peak;
      end
      rd_sum_ff  <= sum_mem[rd_addr];
      rd_peak_ff <= peak_mem[rd_addr];
   end

   // An entry never written since reset holds the cleared value.
   assign rd_sum  = rd_valid_ff ? rd_sum_ff : '0;
   assign rd_peak = rd_valid_ff ? rd_peak_ff : '0;

endmodule

FILE: rtl/audio_block_rms_peak_meter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_block_rms_peak_meter_top
// Multichannel block RMS and peak meter with a serial modulo, divide and root.
// ----------------------------------------------------------------------------
// Each accepted sample beat passes an accept state, 40 steps of the shared
// compare and subtract unit to find the frame index modulo samples_per_point,
// an update state, then, when it closes a point, 64 restoring divide steps and
// 32 square root steps on the same unit, and a final state that loads the
// result register. The result register lets the next sample beat be taken
// while a result still waits. Configuration writes are taken in every cycle
// and must arrive only while the block is idle. All per-channel accumulators
// read as zero after reset.
// ----------------------------------------------------------------------------
module audio_block_rms_peak_meter_top #(
   parameter int MAX_CHANNELS = rpm_pkg::MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = rpm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_BITS-1:0]    req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_point_valid,
   output logic [rpm_pkg::CH_OUT_W-1:0]     rsp_point_channel,
   output logic [SAMPLE_BITS-1:0]           rsp_point_rms,
   output logic [SAMPLE_BITS-1:0]           rsp_point_peak,
   output logic [SAMPLE_BITS-1:0]           rsp_overall_peak,
   output logic [rpm_pkg::FRAME_W-1:0]      rsp_overall_peak_frame,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W  = (CH_W + 1 > rpm_pkg::CHCNT_W) ? CH_W + 1 : rpm_pkg::CHCNT_W;
   localparam int MAG_W  = (SAMPLE_BITS > rpm_pkg::FLOOR_W) ? SAMPLE_BITS : rpm_pkg::FLOOR_W;
   localparam int LIM_W  = rpm_pkg::ROOT_W + 1;
   localparam logic [LIM_W-1:0] RMS_LIMIT = LIM_W'(1) << (SAMPLE_BITS - 1);
   localparam logic [CNT_W-1:0] CH_MAX    = CNT_W'(MAX_CHANNELS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_UPD  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_SQRT = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   // Control state.
   logic [2:0]                    state_ff, state_in;
   logic [rpm_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [CH_W-1:0]               ch_ff, ch_in;
   logic [rpm_pkg::FRAME_W-1:0]   frame_ff, frame_in;
   logic [MAG_W-1:0]              peak_ff, peak_in;
   logic [rpm_pkg::FRAME_W-1:0]   peak_frame_ff, peak_frame_in;
   logic [rpm_pkg::LEN_W-1:0]     spp_ff, spp_in;
   logic [rpm_pkg::CHCNT_W-1:0]   chans_ff, chans_in;
   logic [rpm_pkg::FLOOR_W-1:0]   floor_ff, floor_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Datapath.
   logic [MAG_W-1:0]              mag_ff, mag_in;
   logic [rpm_pkg::SUM_W-1:0]     sq_ff, sq_in;
   logic [rpm_pkg::SUM_W-1:0]     sh_ff, sh_in;
   logic [rpm_pkg::ALU_W-1:0]     rem_ff, rem_in;
   logic [rpm_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic                          emit_ff, emit_in;
   logic [MAG_W-1:0]              pt_peak_ff, pt_peak_in;
   logic [CH_W-1:0]               pt_ch_ff, pt_ch_in;

   // Result register.
   logic                          out_pv_ff, out_pv_in;
   logic [rpm_pkg::CH_OUT_W-1:0]  out_ch_ff, out_ch_in;
   logic [SAMPLE_BITS-1:0]        out_rms_ff, out_rms_in;
   logic [SAMPLE_BITS-1:0]        out_peak_ff, out_peak_in;
   logic [SAMPLE_BITS-1:0]        out_all_ff, out_all_in;
   logic [rpm_pkg::FRAME_W-1:0]   out_frame_ff, out_frame_in;

   logic [SAMPLE_BITS-1:0]        sample_u;
   logic [SAMPLE_BITS-1:0]        sample_abs;
   logic [MAG_W-1:0]              mag_ext;
   logic [MAG_W-1:0]              floor_ext;
   logic [2*MAG_W-1:0]            sq_full;
   logic [rpm_pkg::LEN_W-1:0]     len_eff;
   logic [CNT_W-1:0]              chans_eff;
   logic [CNT_W-1:0]              ch_inc;
   logic [rpm_pkg::SUM_W:0]       sum_wide;
   logic [rpm_pkg::SUM_W-1:0]     new_sum;
   logic [MAG_W-1:0]              new_peak;
   logic                          emit_now;
   logic [LIM_W-1:0]              root_ext;
   logic [SAMPLE_BITS-1:0]        rms_sat;

   logic [rpm_pkg::ALU_W-1:0]     alu_a, alu_b, alu_diff;
   logic                          alu_ge;

   logic                          st_wr_en;
   logic [rpm_pkg::SUM_W-1:0]     st_wr_sum;
   logic [MAG_W-1:0]              st_wr_peak;
   logic [rpm_pkg::SUM_W-1:0]     st_rd_sum;
   logic [MAG_W-1:0]              st_rd_peak;

   rpm_cmpsub u_cmpsub (
      .a    (alu_a),
      .b    (alu_b),
      .ge   (alu_ge),
      .diff (alu_diff)
   );

   rpm_chan_store #(
      .DEPTH  (MAX_CHANNELS),
      .ADDR_W (CH_W),
      .PEAK_W (MAG_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (st_wr_en),
      .wr_addr (ch_ff),
      .wr_sum  (st_wr_sum),
      .wr_peak (st_wr_peak),
      .rd_addr (ch_ff),
      .rd_sum  (st_rd_sum),
      .rd_peak (st_rd_peak)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // Magnitude of the incoming sample; the most negative code maps onto the
   // unsigned value one above the largest positive one without extra logic.
   assign sample_u   = req_sample;
   assign sample_abs = sample_u[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample_u + 1'b1) : sample_u;
   assign mag_ext    = MAG_W'(sample_abs);
   assign floor_ext  = MAG_W'(floor_ff);

   assign sq_full = mag_ff * mag_ff;

   assign len_eff   = (spp_ff == '0) ? rpm_pkg::LEN_W'(1) : spp_ff;
   assign chans_eff = (chans_ff == '0) ? CNT_W'(1) :
                      ((CNT_W'(chans_ff) > CH_MAX) ? CH_MAX : CNT_W'(chans_ff));
   assign ch_inc    = CNT_W'(ch_ff) + CNT_W'(1);

   // Saturating accumulation of the registered square.
   assign sum_wide = {1'b0, st_rd_sum} + {1'b0, sq_ff};
   assign new_sum  = sum_wide[rpm_pkg::SUM_W] ? '1 : sum_wide[rpm_pkg::SUM_W-1:0];
   assign new_peak = (mag_ff > st_rd_peak) ? mag_ff : st_rd_peak;
   assign emit_now = (rem_ff == '0);

   assign root_ext = LIM_W'(root_ff);
   assign rms_sat  = (root_ext > RMS_LIMIT) ? SAMPLE_BITS'(RMS_LIMIT) : SAMPLE_BITS'(root_ff);

   assign st_wr_en   = (state_ff == S_UPD);
   assign st_wr_sum  = emit_now ? '0 : new_sum;
   assign st_wr_peak = emit_now ? '0 : new_peak;

   // Operand selection for the shared unit.
   always_comb begin
      case (state_ff)
         S_SQRT: begin
            alu_a = {rem_ff[rpm_pkg::ALU_W-3:0], sh_ff[rpm_pkg::SUM_W-1 -: 2]};
            alu_b = rpm_pkg::ALU_W'({root_ff, 2'b01});
         end
         default: begin
            alu_a = rpm_pkg::ALU_W'({rem_ff[rpm_pkg::LEN_W-1:0], sh_ff[rpm_pkg::SUM_W-1]});
            alu_b = rpm_pkg::ALU_W'(len_eff);
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      ch_in         = ch_ff;
      frame_in      = frame_ff;
      peak_in       = peak_ff;
      peak_frame_in = peak_frame_ff;
      spp_in        = spp_ff;
      chans_in      = chans_ff;
      floor_in      = floor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mag_in        = mag_ff;
      sq_in         = rpm_pkg::SUM_W'(sq_full);
      sh_in         = sh_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      emit_in       = emit_ff;
      pt_peak_in    = pt_peak_ff;
      pt_ch_in      = pt_ch_ff;
      out_pv_in     = out_pv_ff;
      out_ch_in     = out_ch_ff;
      out_rms_in    = out_rms_ff;
      out_peak_in   = out_peak_ff;
      out_all_in    = out_all_ff;
      out_frame_in  = out_frame_ff;

      if (csr_valid) begin
         case (csr_index)
            rpm_pkg::CSR_SAMPLES_PER_POINT: spp_in   = csr_data[rpm_pkg::LEN_W-1:0];
            rpm_pkg::CSR_CHANNEL_COUNT:     chans_in = csr_data[rpm_pkg::CHCNT_W-1:0];
            rpm_pkg::CSR_FLOOR_LEVEL:       floor_in = csr_data[rpm_pkg::FLOOR_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mag_in   = (mag_ext < floor_ext) ? floor_ext : mag_ext;
               // Frame index at the top of the shift register, remainder clear.
               sh_in    = {frame_ff, rpm_pkg::LEN_W'(0)};
               rem_in   = '0;
               step_in  = rpm_pkg::STEP_W'(rpm_pkg::MOD_STEPS);
               state_in = S_MOD;
            end
         end
         S_MOD, S_DIV: begin
            rem_in  = alu_ge ? alu_diff : alu_a;
            sh_in   = {sh_ff[rpm_pkg::SUM_W-2:0], alu_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == rpm_pkg::STEP_W'(1)) begin
               if (state_ff == S_MOD) begin
                  state_in = S_UPD;
               end else begin
                  // The quotient now sits in the shift register.
                  rem_in   = '0;
                  root_in  = '0;
                  step_in  = rpm_pkg::STEP_W'(rpm_pkg::SQRT_STEPS);
                  state_in = S_SQRT;
               end
            end
         end
         S_UPD: begin
            emit_in    = emit_now;
            pt_peak_in = new_peak;
            // The channel counter moves on here, so the point keeps its own copy.
            pt_ch_in   = ch_ff;
            sh_in      = new_sum;
            rem_in     = '0;
            step_in    = rpm_pkg::STEP_W'(rpm_pkg::DIV_STEPS);
            state_in   = emit_now ? S_DIV : S_FIN;
            if (mag_ff > peak_ff) begin
               peak_in       = mag_ff;
               peak_frame_in = frame_ff;
            end
            if (ch_inc >= chans_eff) begin
               ch_in    = '0;
               frame_in = frame_ff + 1'b1;
            end else begin
               ch_in = ch_inc[CH_W-1:0];
            end
         end
         S_SQRT: begin
            rem_in  = alu_ge ? alu_diff : alu_a;
            root_in = {root_ff[rpm_pkg::ROOT_W-2:0], alu_ge};
            sh_in   = {sh_ff[rpm_pkg::SUM_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == rpm_pkg::STEP_W'(1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_pv_in    = emit_ff;
               out_ch_in    = emit_ff ? rpm_pkg::CH_OUT_W'(pt_ch_ff) : '0;
               out_rms_in   = emit_ff ? rms_sat : '0;
               out_peak_in  = emit_ff ? SAMPLE_BITS'(pt_peak_ff) : '0;
               out_all_in   = SAMPLE_BITS'(peak_ff);
               out_frame_in = peak_frame_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         ch_ff         <= '0;
         frame_ff      <= '0;
         peak_ff       <= '0;
         peak_frame_ff <= '0;
         spp_ff        <= rpm_pkg::LEN_W'(1);
         chans_ff      <= rpm_pkg::CHCNT_W'(1);
         floor_ff      <= rpm_pkg::FLOOR_W'(8);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         ch_ff         <= ch_in;
         frame_ff      <= frame_in;
         peak_ff       <= peak_in;
         peak_frame_ff <= peak_frame_in;
         spp_ff        <= spp_in;
         chans_ff      <= chans_in;
         floor_ff      <= floor_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      sq_ff        <= sq_in;
      sh_ff        <= sh_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      emit_ff      <= emit_in;
      pt_peak_ff   <= pt_peak_in;
      pt_ch_ff     <= pt_ch_in;
      out_pv_ff    <= out_pv_in;
      out_ch_ff    <= out_ch_in;
      out_rms_ff   <= out_rms_in;
      out_peak_ff  <= out_peak_in;
      out_all_ff   <= out_all_in;
      out_frame_ff <= out_frame_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_point_valid        = out_pv_ff;
   assign rsp_point_channel      = out_ch_ff;
   assign rsp_point_rms          = out_rms_ff;
   assign rsp_point_peak         = out_peak_ff;
   assign rsp_overall_peak       = out_all_ff;
   assign rsp_overall_peak_frame = out_frame_ff;

   // An accepted beat always starts the modulo pass.
   a_accept_starts_mod: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_MOD)
      else $error("accepted sample did not start the modulo pass");

   // The modulo pass leaves a remainder below the block length.
   a_mod_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD |-> rem_ff < rpm_pkg::ALU_W'(len_eff))
      else $error("frame remainder not below block length");

   // A beat without a point carries zero point fields.
   a_no_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |->
         rsp_point_rms == '0 && rsp_point_peak == '0 && rsp_point_channel == '0)
      else $error("point fields not cleared on a beat without a point");

   // The result register is only reloaded once the previous beat has gone.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(out_rms_ff))
      else $error("pending result overwritten");

endmodule
